### hdl/rdp_pkg.sv
package rdp_pkg;

    typedef enum logic [3:0] {
        ERR_NONE     = 4'd0,
        ERR_WEEKDAY  = 4'd1,
        ERR_COMMA    = 4'd2,
        ERR_DIGITS   = 4'd3,
        ERR_DAY      = 4'd4,
        ERR_MONTH    = 4'd5,
        ERR_HOUR     = 4'd6,
        ERR_COLON    = 4'd7,
        ERR_MINUTE   = 4'd8,
        ERR_SECOND   = 4'd9,
        ERR_ZONE_END = 4'd10,
        ERR_SIGN     = 4'd11,
        ERR_TRAILING = 4'd12
    } err_t;

    // one classified character
    typedef struct packed {
        logic       term;
        logic       space;
        logic       comma;
        logic       colon;
        logic       plus;
        logic       minus;
        logic       digit;
        logic [3:0] dval;
        logic       alpha;
        logic [7:0] upc;    // uppercase ASCII when alpha, else zero
    } rdp_char_t;

    localparam int NUM_ZONES = 15;
    localparam logic [3:0] ZONE_NUMERIC = 4'd15;

    localparam logic [7:0] WDAY_TAB [7][3] = '{
        '{"S","U","N"}, '{"M","O","N"}, '{"T","U","E"}, '{"W","E","D"},
        '{"T","H","U"}, '{"F","R","I"}, '{"S","A","T"}
    };

    localparam logic [7:0] MON_TAB [12][3] = '{
        '{"J","A","N"}, '{"F","E","B"}, '{"M","A","R"}, '{"A","P","R"},
        '{"M","A","Y"}, '{"J","U","N"}, '{"J","U","L"}, '{"A","U","G"},
        '{"S","E","P"}, '{"O","C","T"}, '{"N","O","V"}, '{"D","E","C"}
    };

    localparam logic [7:0] ZONE_TAB [15][3] = '{
        '{"U","T",8'h00}, '{"G","M","T"}, '{"E","S","T"}, '{"E","D","T"},
        '{"C","S","T"}, '{"C","D","T"}, '{"M","S","T"}, '{"M","D","T"},
        '{"P","S","T"}, '{"P","D","T"}, '{"Z",8'h00,8'h00}, '{"A",8'h00,8'h00},
        '{"M",8'h00,8'h00}, '{"N",8'h00,8'h00}, '{"Y",8'h00,8'h00}
    };

    localparam logic [1:0] ZONE_LEN [15] = '{
        2'd2, 2'd3, 2'd3, 2'd3, 2'd3, 2'd3, 2'd3, 2'd3,
        2'd3, 2'd3, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1
    };

    localparam logic signed [13:0] ZONE_MIN [15] = '{
        14'sd0, 14'sd0, -14'sd300, -14'sd240, -14'sd360, -14'sd300, -14'sd420,
        -14'sd360, -14'sd480, -14'sd420, 14'sd0, -14'sd60, -14'sd720, 14'sd60,
        14'sd720
    };

endpackage

### hdl/rdp_front.sv
module rdp_front
    import rdp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [15:0] in_code,
    output logic        q_valid,
    output rdp_char_t   q_char,
    input  logic        q_pop
);

    rdp_char_t  cls;
    rdp_char_t  mem [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push;
    logic       lower;
    logic       upper;

    always_comb
    begin
        lower     = (in_code >= 16'd97) && (in_code <= 16'd122);
        upper     = (in_code >= 16'd65) && (in_code <= 16'd90);
        cls.term  = (in_code == 16'd0);
        cls.space = (in_code == 16'd32);
        cls.comma = (in_code == 16'd44);
        cls.colon = (in_code == 16'd58);
        cls.plus  = (in_code == 16'd43);
        cls.minus = (in_code == 16'd45);
        cls.digit = (in_code >= 16'd48) && (in_code <= 16'd57);
        cls.dval  = 4'(in_code - 16'd48);
        cls.alpha = lower || upper;
        if (lower)
            cls.upc = 8'(in_code - 16'd32);
        else if (upper)
            cls.upc = in_code[7:0];
        else
            cls.upc = 8'd0;
    end

    assign in_ready = (count_reg != 2'd2);
    assign push     = in_valid && in_ready;
    assign q_valid  = (count_reg != 2'd0);
    assign q_char   = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ q_pop;
        count_next  = 2'(count_reg + {1'b0, push} - {1'b0, q_pop});
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= cls;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

### hdl/rdp_back.sv
module rdp_back
    import rdp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_valid,
    input  rdp_char_t   q_char,
    output logic        q_pop,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] out_data
);

    typedef enum logic [19:0] {
        PH_START  = 20'b1 << 0,
        PH_WDAY   = 20'b1 << 1,
        PH_COMMA  = 20'b1 << 2,
        PH_DAYSP  = 20'b1 << 3,
        PH_DAY1   = 20'b1 << 4,
        PH_DAY2   = 20'b1 << 5,
        PH_MON    = 20'b1 << 6,
        PH_YEAR   = 20'b1 << 7,
        PH_HOUR1  = 20'b1 << 8,
        PH_HOUR2  = 20'b1 << 9,
        PH_COLON  = 20'b1 << 10,
        PH_MIN1   = 20'b1 << 11,
        PH_MIN2   = 20'b1 << 12,
        PH_SECQ   = 20'b1 << 13,
        PH_SEC1   = 20'b1 << 14,
        PH_SEC2   = 20'b1 << 15,
        PH_ZONE   = 20'b1 << 16,
        PH_ZNUM   = 20'b1 << 17,
        PH_ZEND   = 20'b1 << 18,
        PH_ACCEPT = 20'b1 << 19
    } phase_t;

    phase_t       phase_reg, phase_next;
    logic [2:0]   tp_reg, tp_next;
    logic [14:0]  mask_reg, mask_next;
    logic [6:0]   day_reg, day_next;
    logic [3:0]   month_reg, month_next;
    logic [13:0]  year_reg, year_next;
    logic [6:0]   hour_reg, hour_next;
    logic [6:0]   minute_reg, minute_next;
    logic [6:0]   second_reg, second_next;
    logic [6:0]   zhh_reg, zhh_next;     // zone hours digits
    logic [6:0]   zmm_reg, zmm_next;     // zone minutes digits
    logic         zneg_reg, zneg_next;
    logic [3:0]   zidx_reg, zidx_next;
    err_t         err_reg, err_next;
    logic         out_valid_reg, out_valid_next;
    logic [63:0]  out_data_reg, out_data_next;

    function automatic logic [3:0] lowest15(input logic [14:0] m);
        logic [3:0] r;
        r = 4'd0;
        for (int i = NUM_ZONES - 1; i >= 0; i--)
            if (m[i])
                r = 4'(i);
        return r;
    endfunction

    assign q_pop     = q_valid && (!q_char.term || !out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        phase_t             ph;
        logic               done;
        logic [14:0]        m;
        logic [3:0]         li;
        err_t               st;
        logic [12:0]        mag;
        logic signed [13:0] zval;

        phase_next  = phase_reg;
        tp_next     = tp_reg;
        mask_next   = mask_reg;
        day_next    = day_reg;
        month_next  = month_reg;
        year_next   = year_reg;
        hour_next   = hour_reg;
        minute_next = minute_reg;
        second_next = second_reg;
        zhh_next    = zhh_reg;
        zmm_next    = zmm_reg;
        zneg_next   = zneg_reg;
        zidx_next   = zidx_reg;
        err_next    = err_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_data_next  = out_data_reg;
        ph   = phase_reg;
        done = 1'b0;
        m    = 15'd0;
        li   = 4'd0;
        st   = ERR_NONE;
        mag  = 13'd0;
        zval = 14'sd0;

        if (q_pop && err_reg == ERR_NONE)
        begin
            // phases that pass the character on to the next phase
            if (ph == PH_START)
            begin
                if (q_char.alpha)
                begin
                    ph = PH_WDAY;
                    tp_next = 3'd0;
                    mask_next = 15'h007F;
                end
                else
                    ph = PH_DAY1;
            end
            else if (ph == PH_DAYSP && !q_char.space)
                ph = PH_DAY1;
            else if (ph == PH_DAY2 && !q_char.digit)
            begin
                ph = PH_MON;
                tp_next = 3'd0;
                mask_next = 15'h0FFF;
                if (day_reg < 7'd1 || day_reg > 7'd31)
                begin
                    err_next = ERR_DAY;
                    done = 1'b1;
                end
            end
            else if (ph == PH_YEAR && !q_char.digit && tp_reg == 3'd2)
            begin
                if (year_reg < 14'd100)
                    year_next = 14'(year_reg + 14'd1900);
                ph = PH_HOUR1;
            end
            else if (ph == PH_SECQ && !q_char.colon)
            begin
                ph = PH_ZONE;
                tp_next = 3'd0;
                mask_next = 15'h7FFF;
            end

            if (!done)
            begin
                unique case (ph)
                    PH_START, PH_DAYSP, PH_ACCEPT:
                    begin
                    end
                    PH_WDAY:
                    begin
                        for (int i = 0; i < 7; i++)
                            m[i] = mask_next[i] && (tp_next < 3'd3)
                                   && (q_char.upc == WDAY_TAB[i][tp_next[1:0]]);
                        if (m == 15'd0)
                            err_next = ERR_WEEKDAY;
                        else
                        begin
                            mask_next = m;
                            tp_next = 3'(tp_next + 3'd1);
                            if (tp_next == 3'd3)
                                ph = PH_COMMA;
                        end
                    end
                    PH_COMMA:
                        if (q_char.comma)
                            ph = PH_DAYSP;
                        else
                            err_next = ERR_COMMA;
                    PH_DAY1:
                        if (q_char.digit)
                        begin
                            day_next = 7'(q_char.dval);
                            ph = PH_DAY2;
                        end
                        else
                            err_next = ERR_DIGITS;
                    PH_DAY2:
                    begin
                        day_next = 7'(day_reg * 7'd10 + 7'(q_char.dval));
                        ph = PH_MON;
                        tp_next = 3'd0;
                        mask_next = 15'h0FFF;
                        if (day_next < 7'd1 || day_next > 7'd31)
                            err_next = ERR_DAY;
                    end
                    PH_MON:
                        if (!(tp_next == 3'd0 && q_char.space))
                        begin
                            for (int i = 0; i < 12; i++)
                                m[i] = mask_next[i] && (tp_next < 3'd3)
                                       && (q_char.upc == MON_TAB[i][tp_next[1:0]]);
                            if (m == 15'd0)
                                err_next = ERR_MONTH;
                            else
                            begin
                                mask_next = m;
                                tp_next = 3'(tp_next + 3'd1);
                                if (tp_next == 3'd3)
                                begin
                                    month_next = 4'(lowest15(m) + 4'd1);
                                    ph = PH_YEAR;
                                    tp_next = 3'd0;
                                    year_next = 14'd0;
                                end
                            end
                        end
                    PH_YEAR:
                        if (!(tp_reg == 3'd0 && q_char.space))
                        begin
                            if (q_char.digit)
                            begin
                                year_next = 14'(year_reg * 14'd10 + 14'(q_char.dval));
                                tp_next = 3'(tp_reg + 3'd1);
                                if (tp_next == 3'd4)
                                begin
                                    if (year_next < 14'd100)
                                        year_next = 14'(year_next + 14'd1900);
                                    ph = PH_HOUR1;
                                end
                            end
                            else
                                err_next = ERR_DIGITS;
                        end
                    PH_HOUR1:
                        if (!q_char.space)
                        begin
                            if (q_char.digit)
                            begin
                                hour_next = 7'(q_char.dval);
                                ph = PH_HOUR2;
                            end
                            else
                                err_next = ERR_DIGITS;
                        end
                    PH_HOUR2:
                        if (!q_char.digit)
                            err_next = ERR_DIGITS;
                        else
                        begin
                            hour_next = 7'(hour_reg * 7'd10 + 7'(q_char.dval));
                            if (hour_next > 7'd23)
                                err_next = ERR_HOUR;
                            else
                                ph = PH_COLON;
                        end
                    PH_COLON:
                        if (q_char.colon)
                            ph = PH_MIN1;
                        else
                            err_next = ERR_COLON;
                    PH_MIN1:
                        if (q_char.digit)
                        begin
                            minute_next = 7'(q_char.dval);
                            ph = PH_MIN2;
                        end
                        else
                            err_next = ERR_DIGITS;
                    PH_MIN2:
                        if (!q_char.digit)
                            err_next = ERR_DIGITS;
                        else
                        begin
                            minute_next = 7'(minute_reg * 7'd10 + 7'(q_char.dval));
                            if (minute_next > 7'd59)
                                err_next = ERR_MINUTE;
                            else
                                ph = PH_SECQ;
                        end
                    PH_SECQ:
                        ph = PH_SEC1;
                    PH_SEC1:
                        if (q_char.digit)
                        begin
                            second_next = 7'(q_char.dval);
                            ph = PH_SEC2;
                        end
                        else
                            err_next = ERR_DIGITS;
                    PH_SEC2:
                        if (!q_char.digit)
                            err_next = ERR_DIGITS;
                        else
                        begin
                            second_next = 7'(second_reg * 7'd10 + 7'(q_char.dval));
                            if (second_next > 7'd59)
                                err_next = ERR_SECOND;
                            else
                            begin
                                ph = PH_ZONE;
                                tp_next = 3'd0;
                                mask_next = 15'h7FFF;
                            end
                        end
                    PH_ZONE:
                        if (tp_next == 3'd0 && q_char.space)
                        begin
                        end
                        else if (tp_next == 3'd0 && q_char.term)
                            err_next = ERR_ZONE_END;
                        else
                        begin
                            for (int i = 0; i < NUM_ZONES; i++)
                                m[i] = mask_next[i] && (
                                    ({1'b0, ZONE_LEN[i]} <= tp_next) ||
                                    ((tp_next < 3'd3) &&
                                     (q_char.upc == ZONE_TAB[i][tp_next[1:0]])));
                            li = lowest15(m);
                            if (m == 15'd0)
                            begin
                                if (tp_next == 3'd0 && (q_char.plus || q_char.minus))
                                begin
                                    zneg_next = q_char.minus;
                                    zidx_next = ZONE_NUMERIC;
                                    zhh_next = 7'd0;
                                    zmm_next = 7'd0;
                                    ph = PH_ZNUM;
                                    tp_next = 3'd0;
                                end
                                else
                                    err_next = ERR_SIGN;
                            end
                            else if ({1'b0, ZONE_LEN[li]} <= tp_next)
                            begin
                                zidx_next = li;
                                if ({1'b0, ZONE_LEN[li]} == tp_next && q_char.term)
                                    ph = PH_ACCEPT;
                                else
                                    err_next = ERR_ZONE_END;
                            end
                            else
                            begin
                                mask_next = m;
                                tp_next = 3'(tp_next + 3'd1);
                            end
                        end
                    PH_ZNUM:
                        if (!q_char.digit)
                            err_next = ERR_DIGITS;
                        else
                        begin
                            if (tp_reg < 3'd2)
                                zhh_next = 7'(zhh_reg * 7'd10 + 7'(q_char.dval));
                            else
                                zmm_next = 7'(zmm_reg * 7'd10 + 7'(q_char.dval));
                            tp_next = 3'(tp_reg + 3'd1);
                            if (tp_next == 3'd4)
                                ph = PH_ZEND;
                        end
                    PH_ZEND:
                        if (q_char.term)
                            ph = PH_ACCEPT;
                        else
                            err_next = ERR_TRAILING;
                    default:
                    begin
                    end
                endcase
            end
            phase_next = ph;
        end

        if (q_pop && q_char.term)
        begin
            if (err_next != ERR_NONE)
                st = err_next;
            else if (phase_next == PH_ACCEPT)
                st = ERR_NONE;
            else
                st = ERR_ZONE_END;
            mag = 13'(13'(zhh_next) * 13'd60 + 13'(zmm_next));
            if (zidx_next == ZONE_NUMERIC)
                zval = zneg_next ? 14'(14'd0 - {1'b0, mag}) : {1'b0, mag};
            else
                zval = ZONE_MIN[zidx_next];
            out_valid_next = 1'b1;
            if (st == ERR_NONE)
                out_data_next = {6'd0, zval, second_next[5:0], minute_next[5:0],
                                 hour_next[4:0], year_next, month_next,
                                 day_next[4:0], st};
            else
                out_data_next = {60'd0, st};
            phase_next  = PH_START;
            tp_next     = 3'd0;
            mask_next   = 15'h7FFF;
            day_next    = 7'd0;
            month_next  = 4'd0;
            year_next   = 14'd0;
            hour_next   = 7'd0;
            minute_next = 7'd0;
            second_next = 7'd0;
            zhh_next    = 7'd0;
            zmm_next    = 7'd0;
            zneg_next   = 1'b0;
            zidx_next   = 4'd0;
            err_next    = ERR_NONE;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_START;
            tp_reg        <= 3'd0;
            mask_reg      <= 15'h7FFF;
            day_reg       <= 7'd0;
            month_reg     <= 4'd0;
            year_reg      <= 14'd0;
            hour_reg      <= 7'd0;
            minute_reg    <= 7'd0;
            second_reg    <= 7'd0;
            zhh_reg       <= 7'd0;
            zmm_reg       <= 7'd0;
            zneg_reg      <= 1'b0;
            zidx_reg      <= 4'd0;
            err_reg       <= ERR_NONE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            tp_reg        <= tp_next;
            mask_reg      <= mask_next;
            day_reg       <= day_next;
            month_reg     <= month_next;
            year_reg      <= year_next;
            hour_reg      <= hour_next;
            minute_reg    <= minute_next;
            second_reg    <= second_next;
            zhh_reg       <= zhh_next;
            zmm_reg       <= zmm_next;
            zneg_reg      <= zneg_next;
            zidx_reg      <= zidx_next;
            err_reg       <= err_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

### hdl/rfc822_datetime_parser_core.sv
// RFC 822 date-time parser. Characters enter one per beat on s_*, a zero code
// ends the string and yields exactly one result beat on m_*; other characters
// yield none. Throughput is one character per cycle: a two-entry queue holds
// classified characters and the parser consumes one each cycle, stalling only
// when a terminator meets a full, unaccepted result register. A terminator
// beat passes through the queue to the parser, which registers its result;
// a character still waiting ahead of it after a stall, or a result register
// held by m_tready, delays it further. On error, only status is nonzero.
module rfc822_datetime_parser_core
    import rdp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // char_code
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata    // status, day, month, year, hour, minute,
                                   // second, zone_offset_min, zero pad
);

    logic      q_valid;
    logic      q_pop;
    rdp_char_t q_char;

    rdp_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_code  (s_tdata),
        .q_valid  (q_valid),
        .q_char   (q_char),
        .q_pop    (q_pop)
    );

    rdp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_char    (q_char),
        .q_pop     (q_pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata)
    );

endmodule

### sim/rfc822_datetime_parser_checker.sv
`timescale 1ns / 1ps

module rfc822_datetime_parser_checker
    import rdp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [15:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [63:0] m_tdata,
    output int          errors,
    output int          pending
);

    typedef enum logic [4:0] {
        P_START, P_WDAY, P_COMMA, P_DAYSP, P_DAY1, P_DAY2, P_MON, P_YEAR,
        P_HOUR1, P_HOUR2, P_COLON, P_MIN1, P_MIN2, P_SECQ, P_SEC1, P_SEC2,
        P_ZONE, P_ZNUM, P_ZEND, P_ACCEPT
    } parse_phase_t;

    typedef struct packed {
        logic [5:0]  pad;
        logic [13:0] zone;
        logic [5:0]  sec;
        logic [5:0]  min;
        logic [4:0]  hour;
        logic [13:0] year;
        logic [3:0]  mon;
        logic [4:0]  day;
        logic [3:0]  status;
    } datetime_t;

    parse_phase_t ph;
    int           tpos;
    logic [14:0]  mask;
    int           dayv, monv, yearv, hourv, minv, secv, zdig, zidx;
    logic         zneg;
    err_t         ferr;
    datetime_t    parsed_q[$];

    assign pending = parsed_q.size();

    function automatic int up(input int c);
        return (c >= "a" && c <= "z") ? c - 32 : c;
    endfunction

    function automatic bit is_alpha(input int c);
        return up(c) >= "A" && up(c) <= "Z";
    endfunction

    function automatic bit is_digit(input int c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic int lowest(input logic [14:0] m);
        for (int i = 0; i < 15; i++)
            if (m[i])
                return i;
        return 0;
    endfunction

    function bit flag(input err_t e);
        ferr = e;
        return 1'b1;
    endfunction

    function void clear_parse();
        ph = P_START;
        tpos = 0;
        mask = 15'h7FFF;
        dayv = 0; monv = 0; yearv = 0;
        hourv = 0; minv = 0; secv = 0;
        zdig = 0; zneg = 1'b0; zidx = 0;
        ferr = ERR_NONE;
    endfunction

    function void end_year();
        if (yearv < 100)
            yearv += 1900;
        ph = P_HOUR1;
    endfunction

    function void to_zone();
        ph = P_ZONE;
        tpos = 0;
        mask = 15'h7FFF;
    endfunction

    // returns 0 when the character has to be consumed again in the new phase
    function bit feed(input int c);
        int          d;
        logic [14:0] m;
        int          i;
        d = c - "0";
        m = '0;
        case (ph)
            P_START:
            begin
                if (is_alpha(c))
                begin
                    ph = P_WDAY;
                    tpos = 0;
                    mask = 15'h7F;
                end
                else
                    ph = P_DAY1;
                return 1'b0;
            end
            P_WDAY:
            begin
                if (tpos <= 2)
                    for (i = 0; i < 7; i++)
                        if (mask[i] && up(c) == int'(WDAY_TAB[i][tpos]))
                            m[i] = 1'b1;
                if (m == 0)
                    return flag(ERR_WEEKDAY);
                mask = m;
                tpos++;
                if (tpos >= 3)
                    ph = P_COMMA;
                return 1'b1;
            end
            P_COMMA:
            begin
                if (c != ",")
                    return flag(ERR_COMMA);
                ph = P_DAYSP;
                return 1'b1;
            end
            P_DAYSP:
            begin
                if (c == " ")
                    return 1'b1;
                ph = P_DAY1;
                return 1'b0;
            end
            P_DAY1:
            begin
                if (!is_digit(c))
                    return flag(ERR_DIGITS);
                dayv = d;
                ph = P_DAY2;
                return 1'b1;
            end
            P_DAY2:
            begin
                if (is_digit(c))
                    dayv = dayv * 10 + d;
                ph = P_MON;
                tpos = 0;
                mask = 15'hFFF;
                if (dayv < 1 || dayv > 31)
                    return flag(ERR_DAY);
                return is_digit(c);
            end
            P_MON:
            begin
                if (tpos == 0 && c == " ")
                    return 1'b1;
                if (tpos <= 2)
                    for (i = 0; i < 12; i++)
                        if (mask[i] && up(c) == int'(MON_TAB[i][tpos]))
                            m[i] = 1'b1;
                if (m == 0)
                    return flag(ERR_MONTH);
                mask = m;
                tpos++;
                if (tpos >= 3)
                begin
                    monv = lowest(m) + 1;
                    ph = P_YEAR;
                    tpos = 0;
                    yearv = 0;
                end
                return 1'b1;
            end
            P_YEAR:
            begin
                if (tpos == 0 && c == " ")
                    return 1'b1;
                if (is_digit(c))
                begin
                    yearv = yearv * 10 + d;
                    tpos++;
                    if (tpos >= 4)
                        end_year();
                    return 1'b1;
                end
                if (tpos != 2)
                    return flag(ERR_DIGITS);
                end_year();
                return 1'b0;
            end
            P_HOUR1:
            begin
                if (c == " ")
                    return 1'b1;
                if (!is_digit(c))
                    return flag(ERR_DIGITS);
                hourv = d;
                ph = P_HOUR2;
                return 1'b1;
            end
            P_HOUR2:
            begin
                if (!is_digit(c))
                    return flag(ERR_DIGITS);
                hourv = hourv * 10 + d;
                if (hourv > 23)
                    return flag(ERR_HOUR);
                ph = P_COLON;
                return 1'b1;
            end
            P_COLON:
            begin
                if (c != ":")
                    return flag(ERR_COLON);
                ph = P_MIN1;
                return 1'b1;
            end
            P_MIN1:
            begin
                if (!is_digit(c))
                    return flag(ERR_DIGITS);
                minv = d;
                ph = P_MIN2;
                return 1'b1;
            end
            P_MIN2:
            begin
                if (!is_digit(c))
                    return flag(ERR_DIGITS);
                minv = minv * 10 + d;
                if (minv > 59)
                    return flag(ERR_MINUTE);
                ph = P_SECQ;
                return 1'b1;
            end
            P_SECQ:
            begin
                if (c == ":")
                begin
                    ph = P_SEC1;
                    return 1'b1;
                end
                to_zone();
                return 1'b0;
            end
            P_SEC1:
            begin
                if (!is_digit(c))
                    return flag(ERR_DIGITS);
                secv = d;
                ph = P_SEC2;
                return 1'b1;
            end
            P_SEC2:
            begin
                if (!is_digit(c))
                    return flag(ERR_DIGITS);
                secv = secv * 10 + d;
                if (secv > 59)
                    return flag(ERR_SECOND);
                to_zone();
                return 1'b1;
            end
            P_ZONE:
            begin
                if (tpos == 0 && c == " ")
                    return 1'b1;
                if (tpos == 0 && c == 0)
                    return flag(ERR_ZONE_END);
                for (i = 0; i < NUM_ZONES; i++)
                    if (mask[i])
                    begin
                        if (int'(ZONE_LEN[i]) <= tpos)
                            m[i] = 1'b1;
                        else if (tpos < 3 && up(c) == int'(ZONE_TAB[i][tpos]))
                            m[i] = 1'b1;
                    end
                if (m == 0)
                begin
                    if (tpos == 0 && (c == "+" || c == "-"))
                    begin
                        zneg = (c == "-");
                        zidx = ZONE_NUMERIC;
                        zdig = 0;
                        ph = P_ZNUM;
                        tpos = 0;
                        return 1'b1;
                    end
                    return flag(ERR_SIGN);
                end
                i = lowest(m);
                // lowest-indexed surviving name already complete: must end here
                if (int'(ZONE_LEN[i]) <= tpos)
                begin
                    zidx = i;
                    if (int'(ZONE_LEN[i]) == tpos && c == 0)
                    begin
                        ph = P_ACCEPT;
                        return 1'b1;
                    end
                    return flag(ERR_ZONE_END);
                end
                mask = m;
                tpos++;
                return 1'b1;
            end
            P_ZNUM:
            begin
                if (!is_digit(c))
                    return flag(ERR_DIGITS);
                zdig = zdig * 10 + d;
                tpos++;
                if (tpos >= 4)
                    ph = P_ZEND;
                return 1'b1;
            end
            P_ZEND:
            begin
                if (c != 0)
                    return flag(ERR_TRAILING);
                ph = P_ACCEPT;
                return 1'b1;
            end
            default:
                return 1'b1;
        endcase
    endfunction

    function void parse_char(input logic [15:0] code);
        datetime_t r;
        int        mag;
        int        c;
        c = int'(code);
        for (int i = 0; i < 16 && ferr == ERR_NONE; i++)
            if (feed(c))
                break;
        if (c != 0)
            return;
        r = '0;
        if (ferr != ERR_NONE)
            r.status = ferr;
        else if (ph != P_ACCEPT)
            r.status = ERR_ZONE_END;
        else
        begin
            r.status = ERR_NONE;
            r.day = 5'(dayv);
            r.mon = 4'(monv);
            r.year = 14'(yearv);
            r.hour = 5'(hourv);
            r.min = 6'(minv);
            r.sec = 6'(secv);
            if (zidx < NUM_ZONES)
                r.zone = ZONE_MIN[zidx];
            else
            begin
                mag = (zdig / 100) * 60 + zdig % 100;
                r.zone = 14'(zneg ? -mag : mag);
            end
        end
        parsed_q.push_back(r);
        clear_parse();
    endfunction

    task report(input string what, input int got, input int want);
        $display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
        errors++;
    endtask

    initial
    begin
        errors = 0;
        clear_parse();
    end

    always @(posedge clk or negedge rst_n)
    begin
        datetime_t got;
        datetime_t want;
        if (!rst_n)
        begin
            clear_parse();
            parsed_q.delete();
        end
        else
        begin
            if (s_tvalid && s_tready)
                parse_char(s_tdata);
            if (m_tvalid && m_tready)
            begin
                got = m_tdata[63:0];
                if (parsed_q.size() == 0)
                    report("unexpected result beat", int'(got.status), -1);
                else
                begin
                    want = parsed_q.pop_front();
                    if (got.status != want.status) report("status", got.status, want.status);
                    if (got.day != want.day)       report("day", got.day, want.day);
                    if (got.mon != want.mon)       report("month", got.mon, want.mon);
                    if (got.year != want.year)     report("year", got.year, want.year);
                    if (got.hour != want.hour)     report("hour", got.hour, want.hour);
                    if (got.min != want.min)       report("minute", got.min, want.min);
                    if (got.sec != want.sec)       report("second", got.sec, want.sec);
                    if (got.zone != want.zone)
                        report("zone", $signed(got.zone), $signed(want.zone));
                    if (got.pad != want.pad)       report("pad", got.pad, want.pad);
                end
            end
        end
    end

endmodule

### sim/rfc822_datetime_parser_core_tb.sv
`timescale 1ns / 1ps

module rfc822_datetime_parser_core_tb;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;
    int          errors;
    int          pending;

    logic [15:0] text_q[$];
    bit          no_gaps;
    int          stall_left;
    int          sent;

    string wday_names[7] = '{"Sun", "Mon", "Tue", "Wed", "Thu", "Fri", "Sat"};
    string mon_names[12] = '{"Jan", "Feb", "Mar", "Apr", "May", "Jun",
                             "Jul", "Aug", "Sep", "Oct", "Nov", "Dec"};
    string zone_names[15] = '{"UT", "GMT", "EST", "EDT", "CST", "CDT", "MST", "MDT",
                              "PST", "PDT", "Z", "A", "M", "N", "Y"};

    rfc822_datetime_parser_core u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    rfc822_datetime_parser_checker u_checker (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .errors   (errors),
        .pending  (pending)
    );

    initial
        clk = 1'b0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    initial
    begin
        #2000000;
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 65)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // receiver backpressure: mostly ready, short drops, a few long stalls
    always @(posedge clk or negedge rst_n)
    begin
        int r;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            stall_left = 0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            m_tready <= 1'b0;
        end
        else
        begin
            r = $urandom_range(0, 99);
            if (r < 3 && !no_gaps)
                stall_left = $urandom_range(8, 40);
            m_tready <= no_gaps || r >= 25;
        end
    end

    task send_beat(input logic [15:0] code);
        int g;
        s_tvalid <= 1'b1;
        s_tdata <= code;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        g = gap_len();
        if (g > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (g) @(posedge clk);
        end
    endtask

    task send_text();
        foreach (text_q[i])
            send_beat(text_q[i]);
        send_beat(16'd0);
        text_q.delete();
        sent++;
    endtask

    function void put(input string s);
        for (int i = 0; i < s.len(); i++)
            text_q.push_back({8'h00, s[i]});
    endfunction

    function void put_mixed(input string s);
        byte b;
        for (int i = 0; i < s.len(); i++)
        begin
            b = s[i];
            if ($urandom_range(0, 1) && b >= "A" && b <= "Z")
                b = byte'(b + 32);
            text_q.push_back({8'h00, b});
        end
    endfunction

    function void put_num(input int v, input int n);
        for (int i = n - 1; i >= 0; i--)
            text_q.push_back(16'(48 + (v / (10 ** i)) % 10));
    endfunction

    function void put_spaces(input int lo, input int hi);
        repeat ($urandom_range(lo, hi))
            text_q.push_back(16'd32);
    endfunction

    task directed(input string s);
        put(s);
        send_text();
    endtask

    function void build_random();
        int v;
        int k;
        if ($urandom_range(0, 1))
        begin
            put_mixed(wday_names[$urandom_range(0, 6)]);
            put(",");
            put_spaces(0, 2);
        end
        v = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 99) : $urandom_range(1, 31);
        put_num(v, (v < 10 && $urandom_range(0, 1)) ? 1 : 2);
        put_spaces(0, 2);
        put_mixed(mon_names[$urandom_range(0, 11)]);
        put_spaces(0, 2);
        k = $urandom_range(0, 9);
        put_num($urandom_range(0, 9999), k == 0 ? 3 : (k == 1 ? 5 : (k < 5 ? 2 : 4)));
        put_spaces(1, 2);
        put_num(($urandom_range(0, 7) == 0) ? $urandom_range(24, 29) : $urandom_range(0, 23), 2);
        put(":");
        put_num(($urandom_range(0, 7) == 0) ? $urandom_range(60, 69) : $urandom_range(0, 59), 2);
        if ($urandom_range(0, 1))
        begin
            put(":");
            put_num(($urandom_range(0, 7) == 0) ? $urandom_range(60, 69) : $urandom_range(0, 59),
                    2);
        end
        put_spaces(0, 2);
        if ($urandom_range(0, 1))
            put_mixed(zone_names[$urandom_range(0, 14)]);
        else
        begin
            put($urandom_range(0, 1) ? "+" : "-");
            put_num($urandom_range(0, 9999), 4);
        end
        // corrupt a minority of strings
        if ($urandom_range(0, 3) == 0)
        begin
            k = $urandom_range(0, text_q.size() - 1);
            case ($urandom_range(0, 3))
                0: text_q[k] = 16'($urandom_range(0, 65535));
                1: text_q[k] = 16'($urandom_range(32, 126));
                2: text_q.insert(k, 16'($urandom_range(32, 126)));
                default: text_q.delete(k);
            endcase
        end
    endfunction

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        no_gaps = 1'b0;
        sent = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed("Mon, 1 Jan 00 00:00:00 UT");
        directed("sat,31 dec 9999 23:59:59 -9999");
        directed("Xyz, 1 Jan 99 1:00 GMT");
        directed("Sun 1 Jan 99 10:00 GMT");
        directed(" 1 Jan 99 10:00 EST");
        directed("0 Feb 1999 10:00 EDT");
        directed("32 Mar 1999 10:00 CST");
        directed("1 Foo 1999 10:00 CDT");
        directed("1 Apr 199 10:00 MST");
        directed("1 May 19991 0:00 MDT");
        directed("1 Jun 70 24:00 PST");
        directed("1 Jul 70 12-00 PDT");
        directed("1 Aug 70 12:60 Z");
        directed("1 Sep 70 12:00:60 A");
        directed("1 Oct 70 12:00");
        directed("1 Nov 70 12:00 Q");
        directed("1 Dec 70 12:00 +0000x");
        directed("1 Dec 70 12:00 Mx");
        directed("1 Dec 70 12:00 n");
        directed("1 Dec 70 12:00 y");
        directed("");
        text_q.push_back(16'hFFFF);
        send_text();

        // hold off until the parser has drained completely
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);

        while (sent < 50)
        begin
            no_gaps = ($urandom_range(0, 3) == 0);
            build_random();
            send_text();
        end
        no_gaps = 1'b0;
        s_tvalid <= 1'b0;

        while (pending != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

### rfc822_datetime_parser_core.f
hdl/rdp_pkg.sv
hdl/rdp_front.sv
hdl/rdp_back.sv
hdl/rfc822_datetime_parser_core.sv
sim/rfc822_datetime_parser_checker.sv
sim/rfc822_datetime_parser_core_tb.sv
